// ===== design/cat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Connection admission table: shared package
// Table size, field layouts, request and reply codes, and the command that
// the sequencer sends to the entry store.
// ----------------------------------------------------------------------------
package cat_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SCAN_W      = IDX_W + 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LIMIT_W     = 4;
   localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
   localparam logic               REG_LIMIT   = 1'b0;

   localparam logic [1:0] OP_CONNECT    = 2'd0;
   localparam logic [1:0] OP_DISCONNECT = 2'd1;

   localparam logic [1:0] REPLY_DECLINED = 2'd0;
   localparam logic [1:0] REPLY_NEW      = 2'd1;
   localparam logic [1:0] REPLY_EXISTING = 2'd2;
   localparam logic [1:0] REPLY_CLOSED   = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [31:0] request_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [31:0] given_id;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] ip;
      logic [15:0] port;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic             clr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } tbl_cmd_type;

endpackage
`default_nettype wire

// ===== design/cat_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Connection admission table: entry store
// Synchronous entry memory with a registered read port, and the live flags
// of the entries, cleared at reset.
// ----------------------------------------------------------------------------
module cat_store
   import cat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  tbl_cmd_type            cmd,
   output entry_type              rd_data,
   output logic [TABLE_DEPTH-1:0] live
);

   entry_type              mem_ff [TABLE_DEPTH];
   entry_type              rd_data_ff;
   logic [TABLE_DEPTH-1:0] live_ff;
   logic [TABLE_DEPTH-1:0] live_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   always_comb begin
      live_in = live_ff;
      if (cmd.wr_en) begin
         live_in[cmd.wr_addr] = 1'b1;
      end
      if (cmd.clr_en) begin
         live_in[cmd.wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign live    = live_ff;

endmodule
`default_nettype wire

// ===== design/cat_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Connection admission table: request sequencer
// Scans the entry store once per connect or disconnect, decides the reply
// and draws ids from the wrapping counter, each checked by a further scan.
// ----------------------------------------------------------------------------
module cat_seq
   import cat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_type                req_data,
   output logic                   busy,
   input  logic [LIMIT_W-1:0]     limit,
   output tbl_cmd_type            cmd,
   input  entry_type              rd_data,
   input  logic [TABLE_DEPTH-1:0] live,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DRAW   = 3'd3;
   localparam logic [2:0] ST_IDSCAN = 3'd4;
   localparam logic [2:0] ST_IDCHK  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SCAN_W-1:0] cnt_ff, cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              match_fnd_ff, match_fnd_in;
   logic [31:0]       match_id_ff, match_id_in;
   logic              free_fnd_ff, free_fnd_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              hit_fnd_ff, hit_fnd_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              hit_ok_ff, hit_ok_in;
   logic [31:0]       cand_ff, cand_in;
   logic [31:0]       next_id_ff, next_id_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic issue;
   logic scan_last;
   logic elem_live;

   assign issue     = (cnt_ff < SCAN_W'(TABLE_DEPTH));
   assign scan_last = chk_vld_ff && (chk_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign elem_live = live[chk_idx_ff];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      match_fnd_in  = match_fnd_ff;
      match_id_in   = match_id_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      hit_fnd_in    = hit_fnd_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ok_in     = hit_ok_ff;
      cand_in       = cand_ff;
      next_id_in    = next_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      cmd         = '0;
      cmd.rd_addr = cnt_ff[IDX_W-1:0];
      cmd.wr_data = '{id: cand_ff, ip: req_ff.source_ip, port: req_ff.source_port};

      if ((state_ff == ST_SCAN || state_ff == ST_IDSCAN) && issue) begin
         cmd.rd_en  = 1'b1;
         cnt_in     = cnt_ff + SCAN_W'(1);
         chk_vld_in = 1'b1;
         chk_idx_in = cnt_ff[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in       = req_data;
               cnt_in       = '0;
               count_in     = '0;
               match_fnd_in = 1'b0;
               free_fnd_in  = 1'b0;
               hit_fnd_in   = 1'b0;
               hit_ok_in    = 1'b0;
               if (req_data.opcode == OP_CONNECT || req_data.opcode == OP_DISCONNECT) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff) begin
               if (req_ff.opcode == OP_CONNECT) begin
                  if (elem_live && rd_data.ip == req_ff.source_ip) begin
                     count_in = count_ff + CNT_W'(1);
                     if (rd_data.port == req_ff.source_port && !match_fnd_ff) begin
                        match_fnd_in = 1'b1;
                        match_id_in  = rd_data.id;
                     end
                  end
                  if (!elem_live && !free_fnd_ff) begin
                     free_fnd_in = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end else begin
                  if (elem_live && rd_data.id == req_ff.request_id && !hit_fnd_ff) begin
                     hit_fnd_in = 1'b1;
                     hit_idx_in = chk_idx_ff;
                     hit_ok_in  = (rd_data.ip == req_ff.source_ip) &&
                                  (rd_data.port == req_ff.source_port);
                  end
               end
            end
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (req_ff.opcode == OP_CONNECT) begin
               if (CMP_W'(count_ff) >= CMP_W'(limit)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{reply_kind: REPLY_DECLINED, given_id: 32'd0};
               end else if (match_fnd_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{reply_kind: REPLY_EXISTING, given_id: match_id_ff};
               end else if (!free_fnd_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{reply_kind: REPLY_DECLINED, given_id: 32'd0};
               end else begin
                  state_in = ST_DRAW;
               end
            end else if (hit_fnd_ff && hit_ok_ff) begin
               cmd.clr_en    = 1'b1;
               cmd.wr_addr   = hit_idx_ff;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{reply_kind: REPLY_CLOSED, given_id: 32'd0};
            end
         end
         ST_DRAW: begin
            cand_in    = next_id_ff;
            next_id_in = next_id_ff + 32'd1;
            if (next_id_ff != 32'd0) begin
               cnt_in     = '0;
               hit_fnd_in = 1'b0;
               state_in   = ST_IDSCAN;
            end
         end
         ST_IDSCAN: begin
            if (chk_vld_ff && elem_live && rd_data.id == cand_ff) begin
               hit_fnd_in = 1'b1;
            end
            if (scan_last) begin
               state_in = ST_IDCHK;
            end
         end
         ST_IDCHK: begin
            if (hit_fnd_ff) begin
               state_in = ST_DRAW;
            end else begin
               cmd.wr_en     = 1'b1;
               cmd.wr_addr   = free_idx_ff;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{reply_kind: REPLY_NEW, given_id: cand_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         count_ff      <= '0;
         match_fnd_ff  <= 1'b0;
         free_fnd_ff   <= 1'b0;
         hit_fnd_ff    <= 1'b0;
         hit_ok_ff     <= 1'b0;
         next_id_ff    <= 32'd1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_vld_ff    <= chk_vld_in;
         count_ff      <= count_in;
         match_fnd_ff  <= match_fnd_in;
         free_fnd_ff   <= free_fnd_in;
         hit_fnd_ff    <= hit_fnd_in;
         hit_ok_ff     <= hit_ok_in;
         next_id_ff    <= next_id_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      req_ff      <= req_in;
      match_id_ff <= match_id_in;
      free_idx_ff <= free_idx_in;
      hit_idx_ff  <= hit_idx_in;
      cand_ff     <= cand_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

// ===== design/connection_admission_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Connection admission table: top level
// Live connection table with a per-source limit, an id allocator and an
// APB-style register for the limit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Connect requests
// return declined, accepted as new or accepted existing; disconnect requests
// return a reply only when the named id is live and belongs to the sender.
// Other opcodes are taken and dropped without raising busy. Each reply is shown
// on rsp_data for a single cycle, marked by rsp_strobe; the receiver cannot
// stall it.
// Every connect or disconnect request is handled by full passes over the entry
// memory, one entry per cycle through its single read port. A disconnect, a
// decline or an existing connection is answered after one pass; a new
// connection needs a further pass for each nonzero id drawn from the counter.
// A drawn id already in use is skipped, and a drawn zero is skipped without a
// pass. busy falls in the cycle in which the reply is shown, so the next
// request can be taken at the edge that accepts the reply.
// Reset clears the live flags, sets the id counter to one and the limit to
// three. The limit register sits at byte address 0; the user must write it
// only while the block is idle, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
module connection_admission_table_top
   import cat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   tbl_cmd_type            cmd;
   entry_type              rd_data;
   logic [TABLE_DEPTH-1:0] live;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_LIMIT) begin
         limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata = (paddr[ADDR_W-1] == REG_LIMIT) ? DATA_W'(limit_ff) : '0;
   assign pready = 1'b1;

   cat_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .live    (live)
   );

   cat_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .limit      (limit_ff),
      .cmd        (cmd),
      .rd_data    (rd_data),
      .live       (live),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Reply issued without a request in progress.");

   a_single_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two replies issued in consecutive cycles.");

   a_id_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.reply_kind == REPLY_NEW ||
                     rsp_data.reply_kind == REPLY_EXISTING)
      |-> rsp_data.given_id != 32'd0)
      else $error("Accepted connection returned with id zero.");

   a_id_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.reply_kind == REPLY_DECLINED ||
                     rsp_data.reply_kind == REPLY_CLOSED)
      |-> rsp_data.given_id == 32'd0)
      else $error("Declined or disconnect reply carries a non-zero id.");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.opcode == OP_CONNECT ||
                         req_data.opcode == OP_DISCONNECT)
      |=> busy)
      else $error("Connect or disconnect request accepted without going busy.");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection admission table: self-checking testbench
// Drives connect, disconnect and ignored requests, keeps its own copy of the
// connection table and id counter, and compares every reply with the oldest
// predicted one. The per-source limit is changed between phases while the
// block is idle, and the sender's idle rate varies across the phases.
// ----------------------------------------------------------------------------
module tb;
   import cat_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_COUNT   = 7;
   localparam int PHASE_ITEMS   = 236;

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              start   = 1'b0;
   req_type           req_data = '0;
   logic              busy;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0] pwdata  = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   bit          tbl_live [TABLE_DEPTH];
   logic [31:0] tbl_id   [TABLE_DEPTH];
   logic [31:0] tbl_ip   [TABLE_DEPTH];
   logic [15:0] tbl_port [TABLE_DEPTH];
   logic [31:0] next_id   = 32'd1;
   logic [3:0]  limit_val = LIMIT_RESET;

   req_type pending_requests [$];
   rsp_type expected_replies [$];
   int      idle_pct    = 8;
   int      fault_count = 0;

   connection_admission_table_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #10 clock = ~clock;

   function automatic req_type make_req(input logic [1:0] op, input logic [31:0] ip,
                                        input logic [15:0] port, input logic [31:0] id);
      req_type r;
      r.opcode      = op;
      r.source_ip   = ip;
      r.source_port = port;
      r.request_id  = id;
      return r;
   endfunction

   function automatic void admit_request(input req_type r, output bit replied,
                                         output rsp_type rsp);
      int          same_ip;
      int          hit;
      int          vacant;
      logic [31:0] cand;
      bit          taken;
      bit          clash;
      replied = 1'b0;
      rsp     = '0;
      if (r.opcode == OP_CONNECT) begin
         replied = 1'b1;
         same_ip = 0;
         hit     = -1;
         vacant  = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_live[i]) begin
               if (tbl_ip[i] == r.source_ip) begin
                  same_ip++;
                  if (tbl_port[i] == r.source_port && hit < 0) hit = i;
               end
            end else if (vacant < 0) begin
               vacant = i;
            end
         end
         rsp.reply_kind = REPLY_DECLINED;
         if (same_ip < int'(limit_val)) begin
            if (hit >= 0) begin
               rsp.reply_kind = REPLY_EXISTING;
               rsp.given_id   = tbl_id[hit];
            end else if (vacant >= 0) begin
               taken = 1'b0;
               cand  = '0;
               while (!taken) begin
                  cand    = next_id;
                  next_id = next_id + 32'd1;
                  clash   = 1'b0;
                  for (int j = 0; j < TABLE_DEPTH; j++)
                     if (tbl_live[j] && tbl_id[j] == cand) clash = 1'b1;
                  taken = (cand != 32'd0) && !clash;
               end
               tbl_live[vacant] = 1'b1;
               tbl_id[vacant]   = cand;
               tbl_ip[vacant]   = r.source_ip;
               tbl_port[vacant] = r.source_port;
               rsp.reply_kind   = REPLY_NEW;
               rsp.given_id     = cand;
            end
         end
      end else if (r.opcode == OP_DISCONNECT) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_live[i] && tbl_id[i] == r.request_id &&
                tbl_ip[i] == r.source_ip && tbl_port[i] == r.source_port) begin
               tbl_live[i]    = 1'b0;
               replied        = 1'b1;
               rsp.reply_kind = REPLY_CLOSED;
            end
         end
      end
   endfunction

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("tb: fault: %s", msg);
   endtask

   always @(posedge clock) begin : request_driver
      bit      replied;
      rsp_type predicted;
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            void'(pending_requests.pop_front());
            admit_request(req_data, replied, predicted);
            if (replied) expected_replies.push_back(predicted);
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_requests[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : reply_monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            log_fault($sformatf("reply kind %0d id %h with none expected",
                                rsp_data.reply_kind, rsp_data.given_id));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.reply_kind !== want.reply_kind || rsp_data.given_id !== want.given_id)
               log_fault($sformatf("expected kind %0d id %h, actual kind %0d id %h",
                                   want.reply_kind, want.given_id,
                                   rsp_data.reply_kind, rsp_data.given_id));
         end
      end
   end

   task automatic settle();
      while (pending_requests.size() != 0 || expected_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_limit(input logic [3:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * REG_LIMIT);
      pwdata  <= DATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      limit_val = val;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[3:0] !== val)
         log_fault($sformatf("limit read back %h, written %h", prdata[3:0], val));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0]  phase_limit [PHASE_COUNT];
      logic [31:0] ip_pool   [4];
      logic [15:0] port_pool [4];
      int          live_idx  [$];
      int          pick;
      int          k;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] id;
      phase_limit = '{4'd1, 4'd15, 4'd6, 4'd0, 4'd2, 4'd10, 4'd4};
      ip_pool     = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom()};
      port_pool   = '{16'h0000, 16'hFFFF, 16'($urandom()), 16'($urandom())};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Limit of three from reset: new, existing, limit reached, ignored actions,
      // rejected and accepted disconnects, reuse of the lowest free slot.
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'h0, 32'h0));
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'h0, 32'hFFFF_FFFF));
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'hFFFF, 32'h0));
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'h1, 32'h0));
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'h2, 32'h0));
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'h0, 32'h0));
      pending_requests.push_back(make_req(2'd2, 32'h0, 16'h0, 32'h0));
      pending_requests.push_back(make_req(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      pending_requests.push_back(make_req(OP_DISCONNECT, 32'h0, 16'h0, 32'd2));
      pending_requests.push_back(make_req(OP_DISCONNECT, 32'hFFFF_FFFF, 16'hFFFF, 32'd2));
      pending_requests.push_back(make_req(OP_DISCONNECT, 32'h0, 16'hFFFF, 32'd2));
      pending_requests.push_back(make_req(OP_CONNECT, 32'h0, 16'h5, 32'h0));
      settle();
      write_limit(4'd15);

      // Fill the table, then a full-table decline and a match on a full table.
      for (int p = 0; p < 13; p++)
         pending_requests.push_back(make_req(OP_CONNECT, 32'hFFFF_FFFF, 16'(p), 32'h0));
      pending_requests.push_back(make_req(OP_CONNECT, 32'hFFFF_FFFF, 16'd13, 32'h0));
      pending_requests.push_back(make_req(OP_CONNECT, 32'hFFFF_FFFF, 16'd0, 32'h0));
      settle();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_limit(phase_limit[ph]);
         @(negedge clock);
         idle_pct = (ph < 2) ? 8 : (ph < 4) ? 80 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            while (pending_requests.size() != 0) @(negedge clock);
            if (ph == 2 && n == PHASE_ITEMS / 2)
               while (expected_replies.size() != 0) @(negedge clock);
            ip   = ($urandom_range(9) != 0) ? ip_pool[$urandom_range(3)] : $urandom();
            port = ($urandom_range(6) != 0) ? port_pool[$urandom_range(3)] : 16'($urandom());
            pick = $urandom_range(99);
            if (pick < 50) begin
               pending_requests.push_back(make_req(OP_CONNECT, ip, port, $urandom()));
            end else if (pick < 85) begin
               live_idx.delete();
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (tbl_live[i]) live_idx.push_back(i);
               if (live_idx.size() != 0 && $urandom_range(3) != 0) begin
                  k    = live_idx[$urandom_range(live_idx.size() - 1)];
                  id   = tbl_id[k];
                  ip   = tbl_ip[k];
                  port = tbl_port[k];
                  case ($urandom_range(9))
                     0: port = port ^ 16'(1 + $urandom_range(65534));
                     1: ip   = ip ^ (32'd1 << $urandom_range(31));
                     default: ;
                  endcase
               end else begin
                  case ($urandom_range(3))
                     0: id = 32'd0;
                     1: id = next_id;
                     2: id = $urandom_range(next_id);
                     default: id = $urandom();
                  endcase
               end
               pending_requests.push_back(make_req(OP_DISCONNECT, ip, port, id));
            end else begin
               pending_requests.push_back(make_req(2'd2 + 2'($urandom_range(1)), $urandom(),
                                                   16'($urandom()), $urandom()));
            end
         end
         settle();
      end

      if (expected_replies.size() != 0)
         log_fault($sformatf("%0d replies never arrived", expected_replies.size()));
      if (fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #15ms;
      $display("tb: errors");
      $finish;
   end

endmodule
